// ===== rtl/bezf_pkg.sv =====
package bezf_pkg;

	localparam int FRAME_SAMPLES = 30;

	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = SAMPLE_W + 1;
	localparam int SUM_W    = 21;
	localparam int CNT_W    = 6;
	localparam int SCALE_W  = 12;
	localparam int WGT_W    = 9;
	localparam int NF_W     = 15;
	localparam int SENS_W   = 16;
	localparam int EXTRA_W  = 16;
	localparam int TGT_W    = EXTRA_W + 1;

	localparam int RECIP_SH = 26;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / FRAME_SAMPLES);

	localparam int PROD_W   = SUM_W + RECIP_W;
	localparam int SPROD_W  = SUM_W + SENS_W;
	localparam int MIX_W    = SCALE_W + WGT_W;

	localparam logic [SCALE_W-1:0] ONE_Q8   = SCALE_W'(256);
	localparam logic [WGT_W-1:0]   WGT_ONE  = WGT_W'(256);
	localparam logic [EXTRA_W-1:0] EXTRA_MAX = '1;

	localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_SAMPLES);
	localparam logic [SUM_W-1:0] FRAME_DIV = SUM_W'(FRAME_SAMPLES);

	localparam int ADDR_W = 5;
	localparam int IDX_W  = 3;
	localparam logic [IDX_W-1:0] REG_NOISE_FLOOR   = 3'd0;
	localparam logic [IDX_W-1:0] REG_SENSITIVITY   = 3'd1;
	localparam logic [IDX_W-1:0] REG_MAX_SCALE     = 3'd2;
	localparam logic [IDX_W-1:0] REG_ATTACK_WEIGHT = 3'd3;
	localparam logic [IDX_W-1:0] REG_DECAY_WEIGHT  = 3'd4;

	typedef struct packed {
		logic [NF_W-1:0]    noise_floor;
		logic [SENS_W-1:0]  sensitivity;
		logic [SCALE_W-1:0] max_scale;
		logic [WGT_W-1:0]   attack_weight;
		logic [WGT_W-1:0]   decay_weight;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		logic [SUM_W-1:0] sum;
	} push_t;

	typedef struct packed {
		logic             valid;
		logic [SUM_W-1:0] sum;
	} head_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_DIV,
		B_MEAN,
		B_CLEAN,
		B_TARGET,
		B_MIX,
		B_SUM
	} back_state_t;

endpackage

// ===== rtl/bezf_front.sv =====
module bezf_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [bezf_pkg::SAMPLE_W-1:0] s_tdata,
	input  logic                         s_tlast,
	input  logic                         q_full,
	output bezf_pkg::push_t              push
);

	logic [bezf_pkg::SUM_W-1:0] sum_q;
	logic [bezf_pkg::CNT_W-1:0] cnt_q;
	logic [bezf_pkg::MAG_W-1:0] mag;
	logic [bezf_pkg::SUM_W-1:0] sum_next;
	logic                       take;
	logic                       counted;

	assign s_tready = !q_full;
	assign take     = s_tvalid && s_tready;
	assign counted  = cnt_q < bezf_pkg::FRAME_CNT;

	// two's complement magnitude; most negative sample gives 32768
	assign mag = s_tdata[bezf_pkg::SAMPLE_W-1]
		? bezf_pkg::MAG_W'(0) - {1'b1, s_tdata}
		: {1'b0, s_tdata};

	assign sum_next = counted ? sum_q + bezf_pkg::SUM_W'(mag) : sum_q;

	assign push.valid = take && s_tlast;
	assign push.sum   = sum_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (take) begin
			if (s_tlast) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else if (counted) begin
				sum_q <= sum_next;
				cnt_q <= cnt_q + bezf_pkg::CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/bezf_queue.sv =====
module bezf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  bezf_pkg::push_t push,
	input  logic            pop,
	output bezf_pkg::head_t head,
	output logic            full
);

	logic [bezf_pkg::SUM_W-1:0] mem_q [2];
	logic                       wptr_q;
	logic                       rptr_q;
	logic [1:0]                 cnt_q;
	logic                       do_push;
	logic                       do_pop;

	assign full       = cnt_q == 2'd2;
	assign head.valid = cnt_q != 2'd0;
	assign head.sum   = mem_q[rptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push.sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_push) wptr_q <= !wptr_q;
			if (do_pop) rptr_q <= !rptr_q;
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue count out of range");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !full)
		else $error("frame sum pushed into full queue");

endmodule

// ===== rtl/bezf_back.sv =====
module bezf_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bezf_pkg::cfg_t                cfg,
	input  bezf_pkg::head_t               head,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bezf_pkg::SCALE_W-1:0]  zoom
);

	bezf_pkg::back_state_t state_q, state_d;

	logic [bezf_pkg::SUM_W-1:0]   sum_q;
	logic [bezf_pkg::PROD_W-1:0]  prod_q;
	logic [bezf_pkg::SUM_W-1:0]   mean_q;
	logic [bezf_pkg::SPROD_W-1:0] sprod_q;
	logic [bezf_pkg::SCALE_W-1:0] target_q;
	logic [bezf_pkg::WGT_W-1:0]   wgt_q;
	logic [bezf_pkg::MIX_W-1:0]   mix_a_q;
	logic [bezf_pkg::MIX_W-1:0]   mix_b_q;
	logic [bezf_pkg::SCALE_W-1:0] scale_q;
	logic                         ovalid_q;
	logic [bezf_pkg::SCALE_W-1:0] zoom_q;

	logic [bezf_pkg::SUM_W-1:0]   quot0;
	logic [bezf_pkg::SUM_W-1:0]   rem0;
	logic [bezf_pkg::SUM_W-1:0]   mean_d;
	logic [bezf_pkg::SUM_W-1:0]   clean;
	logic [bezf_pkg::SPROD_W-1:0] extra_full;
	logic [bezf_pkg::EXTRA_W-1:0] extra;
	logic [bezf_pkg::TGT_W-1:0]   tgt_raw;
	logic [bezf_pkg::TGT_W-1:0]   tgt_hi;
	logic [bezf_pkg::SCALE_W-1:0] target_d;
	logic [bezf_pkg::WGT_W-1:0]   wgt_raw;
	logic [bezf_pkg::WGT_W-1:0]   wgt_d;
	logic [bezf_pkg::MIX_W-1:0]   mix_sum;
	logic                         out_free;

	assign out_free = !ovalid_q || m_tready;
	assign m_tvalid = ovalid_q;
	assign zoom     = zoom_q;

	// divide by frame length: reciprocal estimate, then one correction step
	assign quot0  = prod_q[bezf_pkg::RECIP_SH +: bezf_pkg::SUM_W];
	assign rem0   = sum_q - bezf_pkg::SUM_W'(quot0 * bezf_pkg::FRAME_DIV);
	assign mean_d = (rem0 >= bezf_pkg::FRAME_DIV) ? quot0 + bezf_pkg::SUM_W'(1) : quot0;

	assign clean = (mean_q > bezf_pkg::SUM_W'(cfg.noise_floor))
		? mean_q - bezf_pkg::SUM_W'(cfg.noise_floor) : '0;

	assign extra_full = sprod_q >> 12;
	assign extra = (extra_full > bezf_pkg::SPROD_W'(bezf_pkg::EXTRA_MAX))
		? bezf_pkg::EXTRA_MAX : extra_full[bezf_pkg::EXTRA_W-1:0];
	assign tgt_raw = bezf_pkg::TGT_W'(bezf_pkg::ONE_Q8) + bezf_pkg::TGT_W'(extra);
	assign tgt_hi  = (tgt_raw > bezf_pkg::TGT_W'(cfg.max_scale))
		? bezf_pkg::TGT_W'(cfg.max_scale) : tgt_raw;
	// lower clamp last: max_scale below one still yields one
	assign target_d = (tgt_hi < bezf_pkg::TGT_W'(bezf_pkg::ONE_Q8))
		? bezf_pkg::ONE_Q8 : tgt_hi[bezf_pkg::SCALE_W-1:0];

	assign wgt_raw = (target_d > scale_q) ? cfg.attack_weight : cfg.decay_weight;
	assign wgt_d   = (wgt_raw > bezf_pkg::WGT_ONE) ? bezf_pkg::WGT_ONE : wgt_raw;

	assign mix_sum = mix_a_q + mix_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bezf_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			bezf_pkg::B_IDLE: begin
				if (head.valid) begin
					pop     = 1'b1;
					state_d = bezf_pkg::B_DIV;
				end
			end
			bezf_pkg::B_DIV:    state_d = bezf_pkg::B_MEAN;
			bezf_pkg::B_MEAN:   state_d = bezf_pkg::B_CLEAN;
			bezf_pkg::B_CLEAN:  state_d = bezf_pkg::B_TARGET;
			bezf_pkg::B_TARGET: state_d = bezf_pkg::B_MIX;
			bezf_pkg::B_MIX:    state_d = bezf_pkg::B_SUM;
			bezf_pkg::B_SUM: begin
				if (out_free) state_d = bezf_pkg::B_IDLE;
			end
			default: state_d = bezf_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bezf_pkg::B_IDLE:   sum_q    <= head.sum;
			bezf_pkg::B_DIV:    prod_q   <= bezf_pkg::PROD_W'(sum_q) *
				bezf_pkg::PROD_W'(bezf_pkg::RECIP);
			bezf_pkg::B_MEAN:   mean_q   <= mean_d;
			bezf_pkg::B_CLEAN:  sprod_q  <= bezf_pkg::SPROD_W'(clean) *
				bezf_pkg::SPROD_W'(cfg.sensitivity);
			bezf_pkg::B_TARGET: begin
				target_q <= target_d;
				wgt_q    <= wgt_d;
			end
			bezf_pkg::B_MIX: begin
				mix_a_q <= bezf_pkg::MIX_W'(scale_q) *
					bezf_pkg::MIX_W'(bezf_pkg::WGT_ONE - wgt_q);
				mix_b_q <= bezf_pkg::MIX_W'(target_q) * bezf_pkg::MIX_W'(wgt_q);
			end
			default: ;
		endcase
		if (state_q == bezf_pkg::B_SUM && out_free) begin
			zoom_q <= mix_sum[8 +: bezf_pkg::SCALE_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= bezf_pkg::ONE_Q8;
			ovalid_q <= 1'b0;
		end else begin
			if (state_q == bezf_pkg::B_SUM && out_free) begin
				scale_q  <= mix_sum[8 +: bezf_pkg::SCALE_W];
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == bezf_pkg::B_IDLE)
		else $error("queue popped while busy");

	a_mean_exact: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bezf_pkg::B_MEAN |-> rem0 < (bezf_pkg::FRAME_DIV + bezf_pkg::FRAME_DIV))
		else $error("reciprocal estimate off by more than one");

	a_scale_min: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> zoom >= bezf_pkg::ONE_Q8)
		else $error("zoom below unity");

endmodule

// ===== rtl/bass_envelope_zoom_follower.sv =====
// Throughput: one sample beat per cycle unless the queue is full; two frame sums queue;
// the arithmetic unit takes one sum at a time through divide, scale, clamp and mix.
// Reset (arst_n low): registers to defaults, sum and count to zero, scale to 1.0,
// no beat pending.
module bass_envelope_zoom_follower (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,   // [15:0] sample
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,   // [11:0] zoom, [15:12] zero
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bezf_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	bezf_pkg::cfg_t  cfg_q;
	bezf_pkg::push_t push;
	bezf_pkg::head_t head;
	logic            q_full;
	logic            pop;
	logic [bezf_pkg::SCALE_W-1:0] zoom;
	logic [bezf_pkg::IDX_W-1:0]   idx;
	logic            wr;

	assign pready = 1'b1;
	assign idx    = paddr[bezf_pkg::ADDR_W-1:2];
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.noise_floor   <= 15'd160;
			cfg_q.sensitivity   <= 16'd983;
			cfg_q.max_scale     <= 12'd640;
			cfg_q.attack_weight <= 9'd205;
			cfg_q.decay_weight  <= 9'd38;
		end else if (wr) begin
			unique case (idx)
				bezf_pkg::REG_NOISE_FLOOR:   cfg_q.noise_floor   <= pwdata[14:0];
				bezf_pkg::REG_SENSITIVITY:   cfg_q.sensitivity   <= pwdata[15:0];
				bezf_pkg::REG_MAX_SCALE:     cfg_q.max_scale     <= pwdata[11:0];
				bezf_pkg::REG_ATTACK_WEIGHT: cfg_q.attack_weight <= pwdata[8:0];
				bezf_pkg::REG_DECAY_WEIGHT:  cfg_q.decay_weight  <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			bezf_pkg::REG_NOISE_FLOOR:   prdata = 32'(cfg_q.noise_floor);
			bezf_pkg::REG_SENSITIVITY:   prdata = 32'(cfg_q.sensitivity);
			bezf_pkg::REG_MAX_SCALE:     prdata = 32'(cfg_q.max_scale);
			bezf_pkg::REG_ATTACK_WEIGHT: prdata = 32'(cfg_q.attack_weight);
			bezf_pkg::REG_DECAY_WEIGHT:  prdata = 32'(cfg_q.decay_weight);
			default:                     prdata = '0;
		endcase
	end

	bezf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.push     (push)
	);

	bezf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.full   (q_full)
	);

	bezf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.zoom     (zoom)
	);

	assign m_tdata = {4'd0, zoom};

endmodule
